### src/glyph_text_to_lcd_writes_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph text to LCD writes block
// Clocked property checks, one with reset gating and one without.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_TO_LCD_WRITES_DEFINES_SVH
`define GLYPH_TEXT_TO_LCD_WRITES_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on the rising edge, ignored while reset is asserted.
`define GTLW_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising edge, reset cycles included.
`define GTLW_ASSERT_ALL(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTLW_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define GTLW_ASSERT_ALL(name, clk, prop, msg)
`endif

`endif

### src/gtlw_pkg.sv
// ----------------------------------------------------------------------------
// Glyph text to LCD writes package
// Payload types, command and status groups, and fixed panel constants.
// ----------------------------------------------------------------------------
package gtlw_pkg;

    // Input item commands.
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Panel controller register indexes used to set up a window.
    localparam logic [15:0] LCD_HADDR  = 16'h0044;
    localparam logic [15:0] LCD_VSTART = 16'h0045;
    localparam logic [15:0] LCD_VEND   = 16'h0046;
    localparam logic [15:0] LCD_XADDR  = 16'h004E;
    localparam logic [15:0] LCD_YADDR  = 16'h004F;
    localparam logic [15:0] LCD_GRAM   = 16'h0022;

    // Pair numbers of the begin sequence (command word then data word).
    localparam logic [2:0] PAIR_HADDR  = 3'd0;
    localparam logic [2:0] PAIR_VSTART = 3'd1;
    localparam logic [2:0] PAIR_VEND   = 3'd2;
    localparam logic [2:0] PAIR_XADDR  = 3'd3;
    localparam logic [2:0] PAIR_YADDR  = 3'd4;
    localparam logic [2:0] PAIR_GRAM   = 3'd5;

    // Index of the final word of the begin sequence.
    localparam logic [3:0] BEGIN_LAST_IDX = 4'd10;

    // Lowest character code that has a glyph in the font.
    localparam logic [7:0] FIRST_GLYPH_CODE = 8'd32;

    // Register file.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_FG     = 3'd0;
    localparam logic [2:0] REG_BG     = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_WRAP   = 3'd4;

    localparam logic [15:0] FG_RESET     = 16'hFFFF;
    localparam logic [15:0] BG_RESET     = 16'h0000;
    localparam logic [5:0]  WIDTH_RESET  = 6'd8;
    localparam logic [5:0]  HEIGHT_RESET = 6'd16;
    localparam logic [9:0]  WRAP_RESET   = 10'd320;

    // Input word.
    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic       first_of_string;
        logic [7:0] start_x;
        logic [8:0] start_y;
        logic [7:0] glyph_byte;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic        is_data;
        logic [15:0] bus_word;
        logic [15:0] font_offset;
        logic        last;
    } t_out_word;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_begin;
        logic load_byte;
        logic calc1;
        logic calc2;
        logic emit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic pix_pending;
        logic last_word;
    } t_stat;

endpackage

### src/gtlw_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph text to LCD writes controller
// Sequences one item at a time and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`include "glyph_text_to_lcd_writes_defines.svh"

module gtlw_ctrl
    import gtlw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC1 = 2'd1;
    localparam logic [1:0] S_CALC2 = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       emit_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    // A word may be loaded when the output register is empty or being drained.
    assign emit_ok     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_cmd == CMD_BEGIN) begin
                        o_cmd.load_begin = 1'b1;
                        n_state          = S_CALC1;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                        if (i_stat.pix_pending) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_word) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Checks.
    `GTLW_ASSERT_CLK(a_begin_calc, i_clk, i_rst_n, (accept && i_in_cmd == CMD_BEGIN) |=> r_state == S_CALC1, "begin item did not start the offset calculation")
    `GTLW_ASSERT_CLK(a_calc_order, i_clk, i_rst_n, r_state == S_CALC1 |=> r_state == S_CALC2, "offset calculation skipped its second step")
    `GTLW_ASSERT_CLK(a_last_done, i_clk, i_rst_n, (o_cmd.emit && i_stat.last_word) |=> (r_state == S_IDLE && r_out_valid), "last word did not end the item")
    `GTLW_ASSERT_CLK(a_word_source, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_EMIT), "output word appeared outside the emit state")
    `GTLW_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not return the controller to idle")

endmodule

### src/gtlw_dp.sv
// ----------------------------------------------------------------------------
// Glyph text to LCD writes datapath
// Cursor, glyph pixel count, font offset arithmetic and the output register.
// ----------------------------------------------------------------------------
module gtlw_dp
    import gtlw_pkg::*;
#(
    parameter int SW = 6
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    input  t_in_word      i_in_data,
    input  logic [SW-1:0] i_width,
    input  logic [SW-1:0] i_height,
    input  logic [15:0]   i_fg,
    input  logic [15:0]   i_bg,
    input  logic [9:0]    i_wrap,
    output t_out_word     o_out_data
);

    localparam int PW  = 2 * SW;
    localparam int PRW = 8 + SW;

    logic [15:0]     r_cursor_x, r_cursor_y;
    logic [PW-1:0]   r_pixels_left;
    logic [15:0]     r_win_x, r_win_y;
    logic [7:0]      r_code_m32;
    logic [PRW-1:0]  r_prod;
    logic [15:0]     r_offset;
    logic [7:0]      r_byte;
    logic [3:0]      r_count;
    logic [3:0]      r_idx;
    logic            r_is_pix;
    t_out_word       r_out;

    logic [15:0]        load_x, load_y;
    logic [15:0]        next_x, next_y;
    logic [15:0]        win_x_end, win_y_end;
    logic signed [17:0] s_next_x, s_limit;
    logic [3:0]         byte_count;
    t_out_word          word;

    // Window origin: start position for the first character, else the cursor.
    assign load_x = i_in_data.first_of_string ? {8'd0, i_in_data.start_x} : r_cursor_x;
    assign load_y = i_in_data.first_of_string ? {7'd0, i_in_data.start_y} : r_cursor_y;

    // Cursor advance with wrap to a new line.
    assign next_x   = r_win_x + 16'(i_width) + 16'd1;
    assign next_y   = r_win_y + 16'(i_height) + 16'd1;
    assign s_next_x = 18'(next_x);
    assign s_limit  = 18'(i_wrap) - 18'(i_width);

    assign win_x_end = r_win_x + 16'(i_width) - 16'd1;
    assign win_y_end = r_win_y + 16'(i_height) - 16'd1;

    // Pixels sent by one glyph byte.
    assign byte_count = (r_pixels_left < PW'(8)) ? 4'(r_pixels_left) : 4'd8;

    // Word selection for the current index.
    always_comb begin
        word = '0;
        if (r_is_pix) begin
            word.is_data  = 1'b1;
            word.bus_word = r_byte[7] ? i_fg : i_bg;
            word.last     = (r_idx == r_count - 4'd1);
        end else begin
            word.is_data     = r_idx[0];
            word.font_offset = r_offset;
            word.last        = (r_idx == BEGIN_LAST_IDX);
            case (r_idx[3:1])
                PAIR_HADDR: begin
                    word.bus_word = r_idx[0] ? ({win_x_end[7:0], 8'd0} + r_win_x) : LCD_HADDR;
                end
                PAIR_VSTART: begin
                    word.bus_word = r_idx[0] ? r_win_y : LCD_VSTART;
                end
                PAIR_VEND: begin
                    word.bus_word = r_idx[0] ? win_y_end : LCD_VEND;
                end
                PAIR_XADDR: begin
                    word.bus_word = r_idx[0] ? r_win_x : LCD_XADDR;
                end
                PAIR_YADDR: begin
                    word.bus_word = r_idx[0] ? r_win_y : LCD_YADDR;
                end
                PAIR_GRAM: begin
                    word.bus_word = LCD_GRAM;
                end
                default: begin
                    word.bus_word = LCD_GRAM;
                end
            endcase
        end
    end

    assign o_stat.pix_pending = (r_pixels_left != '0);
    assign o_stat.last_word   = word.last;
    assign o_out_data         = r_out;

    // Cursor and pixel count, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_pixels_left <= '0;
        end else if (i_cmd.load_begin) begin
            r_cursor_x <= load_x;
            r_cursor_y <= load_y;
        end else if (i_cmd.calc1) begin
            r_pixels_left <= PW'(i_width) * PW'(i_height);
            if (s_next_x > s_limit) begin
                r_cursor_x <= '0;
                r_cursor_y <= next_y;
            end else begin
                r_cursor_x <= next_x;
                r_cursor_y <= r_win_y;
            end
        end else if (i_cmd.load_byte) begin
            r_pixels_left <= r_pixels_left - PW'(byte_count);
        end
    end

    // Item working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_begin) begin
            r_win_x    <= load_x;
            r_win_y    <= load_y;
            r_code_m32 <= (i_in_data.char_code < FIRST_GLYPH_CODE) ? 8'd0 :
                          (i_in_data.char_code - FIRST_GLYPH_CODE);
            r_idx      <= '0;
            r_is_pix   <= 1'b0;
        end
        if (i_cmd.calc1) begin
            r_prod <= PRW'(r_code_m32) * PRW'(i_height);
        end
        if (i_cmd.calc2) begin
            r_offset <= 16'(r_prod) * 16'(i_width >> 3);
        end
        if (i_cmd.load_byte) begin
            r_byte   <= i_in_data.glyph_byte;
            r_count  <= byte_count;
            r_idx    <= '0;
            r_is_pix <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_out <= word;
            r_idx <= r_idx + 4'd1;
            if (r_is_pix) begin
                r_byte <= {r_byte[6:0], 1'b0};
            end
        end
    end

endmodule

### src/glyph_text_to_lcd_writes.sv
// ----------------------------------------------------------------------------
// Glyph text to LCD writes
// Renders characters from a bitmap font as LCD controller bus writes.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Direction
//  input     i_in_valid / o_in_ready / i_in_data      item in
//  output    o_out_valid / i_out_ready / o_out_data   bus word out
//  config    psel penable pwrite paddr pwdata prdata  register access
//
//  A begin item is accepted, runs the offset arithmetic in S_CALC1 and
//  S_CALC2, then gives eleven words, one a cycle unless the output stalls.
//  A glyph byte is accepted and then gives up to eight words, or none
//  when no glyph is active.
//  The output register moves at most one word a cycle and sets the rate.
//  Output stalls hold the word in the register; the next item is taken once
//  the last word of the current one is loaded.
//  Reset is synchronous and clears the cursor, the pixel count and the
//  registers to their defaults.
// ----------------------------------------------------------------------------
module glyph_text_to_lcd_writes
    import gtlw_pkg::*;
#(
    parameter int MAX_GLYPH_SIDE = 32
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW = $clog2(MAX_GLYPH_SIDE + 1);

    logic [15:0]   r_fg, r_bg;
    logic [5:0]    r_width, r_height;
    logic [9:0]    r_wrap;
    logic [SW-1:0] width_eff, height_eff;
    logic          wr_en;
    t_cmd          cmd;
    t_stat         stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg     <= FG_RESET;
            r_bg     <= BG_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_wrap   <= WRAP_RESET;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_FG:     r_fg     <= pwdata[15:0];
                REG_BG:     r_bg     <= pwdata[15:0];
                REG_WIDTH:  r_width  <= pwdata[5:0];
                REG_HEIGHT: r_height <= pwdata[5:0];
                REG_WRAP:   r_wrap   <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (paddr[4:2])
            REG_FG:     prdata = {16'd0, r_fg};
            REG_BG:     prdata = {16'd0, r_bg};
            REG_WIDTH:  prdata = {26'd0, r_width};
            REG_HEIGHT: prdata = {26'd0, r_height};
            REG_WRAP:   prdata = {22'd0, r_wrap};
            default:    prdata = '0;
        endcase
    end

    // Glyph sides clamped to one through the largest supported side.
    always_comb begin
        if (r_width == '0) begin
            width_eff = SW'(1);
        end else if (32'(r_width) > MAX_GLYPH_SIDE) begin
            width_eff = SW'(MAX_GLYPH_SIDE);
        end else begin
            width_eff = SW'(r_width);
        end
        if (r_height == '0) begin
            height_eff = SW'(1);
        end else if (32'(r_height) > MAX_GLYPH_SIDE) begin
            height_eff = SW'(MAX_GLYPH_SIDE);
        end else begin
            height_eff = SW'(r_height);
        end
    end

    gtlw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    gtlw_dp #(
        .SW (SW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_fg       (r_fg),
        .i_bg       (r_bg),
        .i_wrap     (r_wrap),
        .o_out_data (o_out_data)
    );

endmodule

### sim/tb_glyph_text_to_lcd_writes.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph text to LCD writes testbench
// Drives characters and glyph bitmap bytes into the renderer and checks
// every bus word against a cycle-free model of the cursor, window setup and
// pixel color logic. It covers register settings at their extremes,
// clamped glyph sizes, dropped glyphs and stray bytes, and then random text
// with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_glyph_text_to_lcd_writes;
    import gtlw_pkg::*;

    localparam int MAX_SIDE      = 32;
    localparam int SETTLE_CYCLES = 24;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_word          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_word         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Model copy of the registers and of the cursor state.
    logic [15:0] cfg_fg    = FG_RESET;
    logic [15:0] cfg_bg    = BG_RESET;
    logic [5:0]  cfg_width = WIDTH_RESET;
    logic [5:0]  cfg_height = HEIGHT_RESET;
    logic [9:0]  cfg_wrap  = WRAP_RESET;
    int          cur_x     = 0;
    int          cur_y     = 0;
    int          pix_left  = 0;

    t_out_word   lcd_words_due[$];
    int          mismatch_cnt = 0;
    int          sent_cnt     = 0;
    int          stall_cnt    = 0;
    bit          send_fast    = 1'b0;
    bit          recv_fast    = 1'b0;

    glyph_text_to_lcd_writes #(
        .MAX_GLYPH_SIDE(MAX_SIDE)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Effective glyph side: the register value clamped to 1..MAX_SIDE.
    function automatic int side_of(input logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic void push_word(input logic is_data, input int word, input int off,
                                      input logic last);
        t_out_word w;
        w.is_data     = is_data;
        w.bus_word    = word[15:0];
        w.font_offset = off[15:0];
        w.last        = last;
        lcd_words_due.push_back(w);
    endfunction

    // Works out the bus words caused by one word and updates the cursor.
    // Returns how many bus words were queued.
    function automatic int render_item(input t_in_word it);
        int w, h, x, y, x2, y2, off, n, i;
        w = side_of(cfg_width);
        h = side_of(cfg_height);
        if (it.command == CMD_BEGIN) begin
            if (it.first_of_string) begin
                cur_x = int'(it.start_x);
                cur_y = int'(it.start_y);
            end
            x = cur_x & 'hFFFF;
            y = cur_y & 'hFFFF;
            if (it.char_code < FIRST_GLYPH_CODE) begin
                off = 0;
            end else begin
                off = ((int'(it.char_code) - 32) * h * (w / 8)) & 'hFFFF;
            end
            x2 = (x + w - 1) & 'hFFFF;
            y2 = (y + h - 1) & 'hFFFF;
            push_word(1'b0, int'(LCD_HADDR), off, 1'b0);
            push_word(1'b1, (x2 << 8) + x, off, 1'b0);
            push_word(1'b0, int'(LCD_VSTART), off, 1'b0);
            push_word(1'b1, y, off, 1'b0);
            push_word(1'b0, int'(LCD_VEND), off, 1'b0);
            push_word(1'b1, y2, off, 1'b0);
            push_word(1'b0, int'(LCD_XADDR), off, 1'b0);
            push_word(1'b1, x, off, 1'b0);
            push_word(1'b0, int'(LCD_YADDR), off, 1'b0);
            push_word(1'b1, y, off, 1'b0);
            push_word(1'b0, int'(LCD_GRAM), off, 1'b1);
            // Advance the cursor; the wrap test is a signed compare.
            x = (x + w + 1) & 'hFFFF;
            if (x > int'(cfg_wrap) - w) begin
                x = 0;
                y = (y + h + 1) & 'hFFFF;
            end
            cur_x    = x;
            cur_y    = y;
            pix_left = w * h;
            return 11;
        end
        // Glyph byte: one color word per bit, MSB first, until the glyph is done.
        n = (pix_left < 8) ? pix_left : 8;
        for (i = 0; i < n; i++) begin
            push_word(1'b1, it.glyph_byte[7-i] ? int'(cfg_fg) : int'(cfg_bg), 0, i == n - 1);
        end
        pix_left -= n;
        return n;
    endfunction

    function automatic t_in_word make_begin(input logic [7:0] code, input logic first,
                                            input logic [7:0] sx, input logic [8:0] sy);
        t_in_word it;
        it.command         = CMD_BEGIN;
        it.char_code       = code;
        it.first_of_string = first;
        it.start_x         = sx;
        it.start_y         = sy;
        it.glyph_byte      = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Fields that a glyph byte ignores carry random noise.
    function automatic t_in_word make_byte(input logic [7:0] b);
        t_in_word it;
        it.command         = CMD_BYTE;
        it.char_code       = 8'($urandom_range(0, 255));
        it.first_of_string = 1'($urandom_range(0, 1));
        it.start_x         = 8'($urandom_range(0, 255));
        it.start_y         = 9'($urandom_range(0, 511));
        it.glyph_byte      = b;
        return it;
    endfunction

    function automatic logic [5:0] pick_side();
        if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, 12));
    endfunction

    // Sends one word after a random gap and predicts its bus words on acceptance.
    task automatic send_item(input t_in_word it);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        void'(render_item(it));
        sent_cnt++;
    endtask

    // Waits until every predicted bus word has left, then lets the block settle.
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (lcd_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FG:     cfg_fg     = val[15:0];
            REG_BG:     cfg_bg     = val[15:0];
            REG_WIDTH:  cfg_width  = val[5:0];
            REG_HEIGHT: cfg_height = val[5:0];
            REG_WRAP:   cfg_wrap   = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] fg, input logic [15:0] bg,
                              input logic [5:0] w, input logic [5:0] h, input logic [9:0] wrap);
        write_reg(REG_FG, {16'd0, fg});
        write_reg(REG_BG, {16'd0, bg});
        write_reg(REG_WIDTH, {26'd0, w});
        write_reg(REG_HEIGHT, {26'd0, h});
        write_reg(REG_WRAP, {22'd0, wrap});
    endtask

    // Default registers: stray byte, extreme start, dropped glyph, code edges.
    task automatic test_reset_config();
        send_item(make_byte(8'hFF));
        send_item(make_begin(8'd0, 1'b1, 8'd255, 9'd511));
        send_item(make_byte(8'hFF));
        send_item(make_byte(8'h00));
        send_item(make_begin(8'd255, 1'b0, 8'd0, 9'd0));
        send_item(make_begin(8'd31, 1'b0, 8'd17, 9'd300));
        send_item(make_begin(8'd32, 1'b0, 8'd90, 9'd45));
    endtask

    // 3x3 glyph: a byte ends mid-stream, a byte after the glyph is ignored,
    // and a wrap limit below the width forces a new line every character.
    task automatic test_small_glyph();
        drain_words();
        set_config(16'h1234, 16'hEDCB, 6'd3, 6'd3, 10'd1);
        send_item(make_begin(8'd65, 1'b1, 8'd0, 9'd0));
        send_item(make_byte(8'hA5));
        send_item(make_byte(8'h5A));
        send_item(make_byte(8'h3C));
        send_item(make_begin(8'd127, 1'b0, 8'd200, 9'd10));
    endtask

    // Register values outside 1..MAX_SIDE are clamped on both axes.
    task automatic test_clamped_sizes();
        drain_words();
        set_config(16'h0000, 16'hFFFF, 6'd0, 6'd63, 10'd1023);
        send_item(make_begin(8'h7E, 1'b1, 8'd255, 9'd0));
        send_item(make_byte(8'h80));
        send_item(make_byte(8'h01));
        send_item(make_begin(8'h20, 1'b0, 8'd3, 9'd3));
        drain_words();
        set_config(16'hFFFF, 16'h0000, 6'd63, 6'd0, 10'd1023);
        send_item(make_begin(8'd255, 1'b1, 8'd0, 9'd511));
        send_item(make_byte(8'hC3));
        send_item(make_byte(8'h3C));
        send_item(make_byte(8'h81));
        send_item(make_byte(8'h7E));
        send_item(make_byte(8'h99));
    endtask

    // One phase of random text under a random register setting. Most glyphs
    // get exactly their bytes; some are cut short or followed by stray bytes.
    task automatic random_text_phase(input int n_items);
        int target, r, nbytes, k;
        drain_words();
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), pick_side(),
                   pick_side(),
                   ($urandom_range(0, 2) == 0) ? 10'($urandom_range(0, 40)) :
                                                 10'($urandom_range(0, 1023)));
        send_fast = ($urandom_range(0, 3) == 0);
        recv_fast = ($urandom_range(0, 3) == 0);
        target = sent_cnt + n_items;
        while (sent_cnt < target) begin
            r = $urandom_range(0, 9);
            if (r == 9) begin
                send_item(make_byte(8'($urandom_range(0, 255))));
            end else begin
                send_item(make_begin(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                                     8'($urandom_range(0, 255)), 9'($urandom_range(0, 511))));
                nbytes = (side_of(cfg_width) * side_of(cfg_height) + 7) / 8;
                if (r >= 7) nbytes = $urandom_range(0, nbytes);
                for (k = 0; k < nbytes && sent_cnt < target; k++) begin
                    send_item(make_byte(8'($urandom_range(0, 255))));
                end
            end
        end
    endtask

    task automatic test_random_text();
        int p;
        for (p = 0; p < 6; p++) begin
            random_text_phase(48);
        end
        send_fast = 1'b0;
        recv_fast = 1'b0;
    endtask

    // Output side: after each accepted word the receiver stalls a random time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            stall_cnt = recv_fast ? 0 : $urandom_range(0, 11);
            i_out_ready <= (stall_cnt == 0);
        end else begin
            if (stall_cnt > 0) stall_cnt = stall_cnt - 1;
            if (stall_cnt == 0) i_out_ready <= 1'b1;
        end
    end

    // Each accepted bus word is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lcd_words_due.size() == 0) begin
                $error("unexpected bus word %h (is_data %b)", o_out_data.bus_word,
                       o_out_data.is_data);
                mismatch_cnt++;
            end else begin
                want = lcd_words_due.pop_front();
                if (o_out_data.is_data !== want.is_data) begin
                    $error("is_data: expected %b, got %b", want.is_data, o_out_data.is_data);
                    mismatch_cnt++;
                end
                if (o_out_data.bus_word !== want.bus_word) begin
                    $error("bus_word: expected %h, got %h", want.bus_word, o_out_data.bus_word);
                    mismatch_cnt++;
                end
                if (o_out_data.font_offset !== want.font_offset) begin
                    $error("font_offset: expected %h, got %h", want.font_offset,
                           o_out_data.font_offset);
                    mismatch_cnt++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_out_data.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_small_glyph();
        test_clamped_sizes();
        test_random_text();
        drain_words();
        if (mismatch_cnt == 0 && lcd_words_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/gtlw_pkg.sv
src/gtlw_ctrl.sv
src/gtlw_dp.sv
src/glyph_text_to_lcd_writes.sv
sim/tb_glyph_text_to_lcd_writes.sv
